FILE: design/assert_macros.svh
// assertion macros used by the top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: design/etb_pkg.sv
// shared types, constants and functions for the edge tangent block
package etb_pkg;
    localparam int DEF_INDEX_BITS = 16;
    localparam int MAG_BITS = 33;
    localparam int LEN_BITS = 31;
    localparam int Q_BITS = 16;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = 2;

    typedef struct packed {
        logic [Q_BITS-1:0] idx;
        logic [MAG_BITS-1:0] dx;
        logic [MAG_BITS-1:0] dy;
        logic [MAG_BITS-1:0] dz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
    } edge_t;

    typedef struct packed {
        logic [29:0] ax;
        logic [29:0] ay;
        logic [29:0] az;
        logic sx;
        logic sy;
        logic sz;
        logic zero;
    } nrm_in_t;

    typedef struct packed {
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic zero;
    } nrm_out_t;

    // magnitude of a signed value, one bit wider than needed
    function automatic logic [MAG_BITS-1:0] mag33(input logic [MAG_BITS-1:0] v);
        mag33 = v[MAG_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // leading one position of a 33-bit value
    function automatic logic [5:0] lead33(input logic [MAG_BITS-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < MAG_BITS; i++)
            if (v[i])
                p = 6'(i);
        lead33 = p;
    endfunction
endpackage

FILE: design/etb_norm.sv
// pipelined fixed point vector normalizer
module etb_norm
    import etb_pkg::*;
#(
    parameter int TAG_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                stall,
    input  logic [MAG_BITS-1:0] in_x,
    input  logic [MAG_BITS-1:0] in_y,
    input  logic [MAG_BITS-1:0] in_z,
    input  logic [TAG_BITS-1:0] in_tag,
    output logic                out_valid,
    output nrm_out_t            out_q,
    output logic [TAG_BITS-1:0] out_tag
);
    // stage a: sign and magnitude, scaled so the largest is in [2^29, 2^30)
    logic    a_v_reg;
    nrm_in_t a_reg;
    logic [TAG_BITS-1:0] a_tag_reg;
    logic [MAG_BITS-1:0] mx, my, mz, mm;
    logic [5:0] ld;
    nrm_in_t a_next;

    always_comb
    begin
        mx = mag33(in_x);
        my = mag33(in_y);
        mz = mag33(in_z);
        mm = mx | my | mz;
        ld = lead33(mm);
        a_next.sx = in_x[MAG_BITS-1];
        a_next.sy = in_y[MAG_BITS-1];
        a_next.sz = in_z[MAG_BITS-1];
        a_next.zero = (mm == '0);
        if (ld >= 6'd29)
        begin
            a_next.ax = 30'(mx >> (ld - 6'd29));
            a_next.ay = 30'(my >> (ld - 6'd29));
            a_next.az = 30'(mz >> (ld - 6'd29));
        end
        else
        begin
            a_next.ax = 30'(mx << (6'd29 - ld));
            a_next.ay = 30'(my << (6'd29 - ld));
            a_next.az = 30'(mz << (6'd29 - ld));
        end
    end

    // stage b: squares
    logic    b_v_reg;
    nrm_in_t b_reg;
    logic [TAG_BITS-1:0] b_tag_reg;
    logic [59:0] sqx_reg, sqy_reg, sqz_reg;
    // stage c: sum
    logic    c_v_reg;
    nrm_in_t c_reg;
    logic [TAG_BITS-1:0] c_tag_reg;
    logic [61:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a_reg <= a_next;
            a_tag_reg <= in_tag;
            b_reg <= a_reg;
            b_tag_reg <= a_tag_reg;
            sqx_reg <= 60'(a_reg.ax) * 60'(a_reg.ax);
            sqy_reg <= 60'(a_reg.ay) * 60'(a_reg.ay);
            sqz_reg <= 60'(a_reg.az) * 60'(a_reg.az);
            c_reg <= b_reg;
            c_tag_reg <= b_tag_reg;
            sum_reg <= 62'(sqx_reg) + 62'(sqy_reg) + 62'(sqz_reg);
        end
    end

    // square root, one result bit per stage
    logic    s_v_reg [SQRT_STEPS+1];
    nrm_in_t s_reg [SQRT_STEPS+1];
    logic [TAG_BITS-1:0] s_tag_reg [SQRT_STEPS+1];
    logic [61:0] s_rem_reg [SQRT_STEPS+1];
    logic [LEN_BITS-1:0] s_root_reg [SQRT_STEPS+1];

    always_comb
    begin
        s_v_reg[0] = c_v_reg;
        s_reg[0] = c_reg;
        s_tag_reg[0] = c_tag_reg;
        s_rem_reg[0] = sum_reg;
        s_root_reg[0] = '0;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - k;
        logic [LEN_BITS-1:0] trial;
        logic [61:0] tsq;
        logic [61:0] sub;
        always_comb
        begin
            trial = s_root_reg[k] | (LEN_BITS'(1) << B);
            // r^2 is not held; use remainder form: rem >= (2*root + bit) << bit
            sub = ((62'(s_root_reg[k]) << (B + 1)) | (62'(1) << (2 * B)));
            tsq = 62'(trial);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_v_reg[k+1] <= 1'b0;
            else if (!stall)
                s_v_reg[k+1] <= s_v_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (!stall)
            begin
                s_reg[k+1] <= s_reg[k];
                s_tag_reg[k+1] <= s_tag_reg[k];
                if (s_rem_reg[k] >= sub)
                begin
                    s_rem_reg[k+1] <= s_rem_reg[k] - sub;
                    s_root_reg[k+1] <= LEN_BITS'(tsq);
                end
                else
                begin
                    s_rem_reg[k+1] <= s_rem_reg[k];
                    s_root_reg[k+1] <= s_root_reg[k];
                end
            end
        end
    end

    // division: (a*32768 + L) / (2L), quotient at most 16384, one quotient bit a stage
    logic    d_v_reg [DIV_STEPS+1];
    nrm_in_t d_reg [DIV_STEPS+1];
    logic [TAG_BITS-1:0] d_tag_reg [DIV_STEPS+1];
    logic [LEN_BITS:0] d_den_reg [DIV_STEPS+1];
    logic [46:0] d_num_reg [DIV_STEPS+1][3];
    logic [15:0] d_q_reg [DIV_STEPS+1][3];

    always_comb
    begin
        d_v_reg[0] = s_v_reg[SQRT_STEPS];
        d_reg[0] = s_reg[SQRT_STEPS];
        d_tag_reg[0] = s_tag_reg[SQRT_STEPS];
        d_den_reg[0] = {s_root_reg[SQRT_STEPS], 1'b0};
        d_num_reg[0][0] = (47'(s_reg[SQRT_STEPS].ax) << 15) + 47'(s_root_reg[SQRT_STEPS]);
        d_num_reg[0][1] = (47'(s_reg[SQRT_STEPS].ay) << 15) + 47'(s_root_reg[SQRT_STEPS]);
        d_num_reg[0][2] = (47'(s_reg[SQRT_STEPS].az) << 15) + 47'(s_root_reg[SQRT_STEPS]);
        d_q_reg[0][0] = '0;
        d_q_reg[0][1] = '0;
        d_q_reg[0][2] = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - k;
        logic [46:0] sh;
        always_comb
            sh = 47'(d_den_reg[k]) << B;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v_reg[k+1] <= 1'b0;
            else if (!stall)
                d_v_reg[k+1] <= d_v_reg[k];
        end
        for (genvar c = 0; c < 3; c++)
        begin : g_c
            always_ff @(posedge clk)
            begin
                if (!stall)
                begin
                    if (d_num_reg[k][c] >= sh)
                    begin
                        d_num_reg[k+1][c] <= d_num_reg[k][c] - sh;
                        d_q_reg[k+1][c] <= d_q_reg[k][c] | (16'(1) << B);
                    end
                    else
                    begin
                        d_num_reg[k+1][c] <= d_num_reg[k][c];
                        d_q_reg[k+1][c] <= d_q_reg[k][c];
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (!stall)
            begin
                d_reg[k+1] <= d_reg[k];
                d_tag_reg[k+1] <= d_tag_reg[k];
                d_den_reg[k+1] <= d_den_reg[k];
            end
        end
    end

    // sign back on, zero vector forced to zero
    logic     o_v_reg;
    nrm_out_t o_reg;
    logic [TAG_BITS-1:0] o_tag_reg;
    nrm_out_t o_next;
    nrm_in_t  df;

    always_comb
    begin
        df = d_reg[DIV_STEPS];
        o_next.zero = df.zero;
        o_next.qx = df.zero ? '0 : (df.sx ? -d_q_reg[DIV_STEPS][0] : d_q_reg[DIV_STEPS][0]);
        o_next.qy = df.zero ? '0 : (df.sy ? -d_q_reg[DIV_STEPS][1] : d_q_reg[DIV_STEPS][1]);
        o_next.qz = df.zero ? '0 : (df.sz ? -d_q_reg[DIV_STEPS][2] : d_q_reg[DIV_STEPS][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (!stall)
            o_v_reg <= d_v_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            o_reg <= o_next;
            o_tag_reg <= d_tag_reg[DIV_STEPS];
        end
    end

    assign out_valid = o_v_reg;
    assign out_q = o_reg;
    assign out_tag = o_tag_reg;
endmodule

FILE: design/etb_front.sv
// front end: edge vector and queue of edge items
module etb_front
    import etb_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [15:0]           vertex_index,
    input  logic signed [31:0]    from_x,
    input  logic signed [31:0]    from_y,
    input  logic signed [31:0]    from_z,
    input  logic signed [31:0]    to_x,
    input  logic signed [31:0]    to_y,
    input  logic signed [31:0]    to_z,
    input  logic signed [15:0]    normal_x,
    input  logic signed [15:0]    normal_y,
    input  logic signed [15:0]    normal_z,
    input  logic                  take,
    output logic                  avail,
    output edge_t                 item
);
    edge_t mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wp_reg, rp_reg;
    logic [FIFO_PTR_BITS:0] cnt_reg;
    logic wr, rd;
    edge_t e;

    always_comb
    begin
        e.idx = vertex_index & 16'((33'd1 << INDEX_BITS) - 33'd1);
        e.dx = 33'(to_x) - 33'(from_x);
        e.dy = 33'(to_y) - 33'(from_y);
        e.dz = 33'(to_z) - 33'(from_z);
        e.nx = normal_x;
        e.ny = normal_y;
        e.nz = normal_z;
    end

    assign full = (cnt_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign avail = (cnt_reg != '0);
    assign wr = push && !full;
    assign rd = take && avail;
    assign item = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (FIFO_PTR_BITS+1)'(wr) - (FIFO_PTR_BITS+1)'(rd);
        end
    end
endmodule

FILE: design/etb_back.sv
// back end: tangent, cross product, binormal
module etb_back
    import etb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  edge_t         item,
    input  logic          stall,
    output logic          out_valid,
    output logic [15:0]   idx,
    output nrm_out_t      tan,
    output nrm_out_t      bin
);
    localparam int TB1 = 16 + 48;
    localparam int TB2 = 16 + 48 + 1;

    logic t_v;
    nrm_out_t t_q;
    logic [TB1-1:0] t_tag;

    etb_norm #(.TAG_BITS(TB1)) u_tan (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .stall(stall),
        .in_x(item.dx), .in_y(item.dy), .in_z(item.dz),
        .in_tag({item.idx, item.nx, item.ny, item.nz}),
        .out_valid(t_v), .out_q(t_q), .out_tag(t_tag)
    );

    // cross product stage
    logic c_v_reg;
    logic [MAG_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [TB2-1:0] c_tag_reg;
    logic signed [15:0] tx, ty, tz, nx, ny, nz;

    always_comb
    begin
        tx = t_q.qx;
        ty = t_q.qy;
        tz = t_q.qz;
        nx = t_tag[47:32];
        ny = t_tag[31:16];
        nz = t_tag[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (!stall)
            c_v_reg <= t_v;
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            cx_reg <= 33'(32'(ty) * 32'(nz)) - 33'(32'(tz) * 32'(ny));
            cy_reg <= 33'(32'(tz) * 32'(nx)) - 33'(32'(tx) * 32'(nz));
            cz_reg <= 33'(32'(tx) * 32'(ny)) - 33'(32'(ty) * 32'(nx));
            c_tag_reg <= {t_tag[TB1-1:48], t_q.qx, t_q.qy, t_q.qz, t_q.zero};
        end
    end

    logic [TB2-1:0] b_tag;
    nrm_out_t b_q;

    etb_norm #(.TAG_BITS(TB2)) u_bin (
        .clk(clk), .rst_n(rst_n), .in_valid(c_v_reg), .stall(stall),
        .in_x(cx_reg), .in_y(cy_reg), .in_z(cz_reg), .in_tag(c_tag_reg),
        .out_valid(out_valid), .out_q(b_q), .out_tag(b_tag)
    );

    always_comb
    begin
        idx = b_tag[TB2-1:49];
        tan.qx = b_tag[48:33];
        tan.qy = b_tag[32:17];
        tan.qz = b_tag[16:1];
        tan.zero = b_tag[0];
        bin = b_q;
    end
endmodule

FILE: design/edge_tangent_binormal.sv
// edge_tangent_binormal: pipelined tangent and binormal from one edge
// throughput: one edge per cycle while pop keeps up, set by the fully pipelined normalizers
// the back pipeline stalls as a whole when its output register is held
// reset clears all queue pointers and valid bits; payload is not reset
`include "assert_macros.svh"
module edge_tangent_binormal
    import etb_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [15:0]         vertex_index,
    input  logic signed [31:0]  from_x,
    input  logic signed [31:0]  from_y,
    input  logic signed [31:0]  from_z,
    input  logic signed [31:0]  to_x,
    input  logic signed [31:0]  to_y,
    input  logic signed [31:0]  to_z,
    input  logic signed [15:0]  normal_x,
    input  logic signed [15:0]  normal_y,
    input  logic signed [15:0]  normal_z,
    output logic                empty,
    input  logic                pop,
    output logic [15:0]         out_index,
    output logic signed [15:0]  tangent_x,
    output logic signed [15:0]  tangent_y,
    output logic signed [15:0]  tangent_z,
    output logic signed [15:0]  binormal_x,
    output logic signed [15:0]  binormal_y,
    output logic signed [15:0]  binormal_z,
    output logic                degenerate
);
    logic avail, take, stall, bv;
    edge_t item;
    logic [15:0] bidx;
    nrm_out_t tan, bin;
    logic o_v_reg;

    etb_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .vertex_index(vertex_index),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .take(take), .avail(avail), .item(item)
    );

    // pipeline advances when the output register is free or being popped
    assign stall = o_v_reg && !pop;
    assign take = !stall;

    etb_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(avail), .item(item), .stall(stall),
        .out_valid(bv), .idx(bidx), .tan(tan), .bin(bin)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (!stall)
            o_v_reg <= bv;
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            out_index <= bidx;
            tangent_x <= tan.qx;
            tangent_y <= tan.qy;
            tangent_z <= tan.qz;
            binormal_x <= bin.qx;
            binormal_y <= bin.qy;
            binormal_z <= bin.qz;
            degenerate <= tan.zero || bin.zero;
        end
    end

    assign empty = !o_v_reg;

    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty)
    `ASSERT_NEXT(a_idx_hold, clk, rst_n, !empty && !pop, $stable(out_index))
    `ASSERT_IMPLIES(a_deg_zero, clk, rst_n, !empty && degenerate == 1'b0,
        binormal_x != 16'd0 || binormal_y != 16'd0 || binormal_z != 16'd0)
endmodule

FILE: tb/sv/edge_tangent_binormal_check.sv
// checker for the edge tangent block: predicts each result and compares the result channel
module edge_tangent_binormal_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [15:0]        vertex_index,
    input  logic signed [31:0] from_x,
    input  logic signed [31:0] from_y,
    input  logic signed [31:0] from_z,
    input  logic signed [31:0] to_x,
    input  logic signed [31:0] to_y,
    input  logic signed [31:0] to_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic               empty,
    input  logic               pop,
    input  logic [15:0]        out_index,
    input  logic signed [15:0] tangent_x,
    input  logic signed [15:0] tangent_y,
    input  logic signed [15:0] tangent_z,
    input  logic signed [15:0] binormal_x,
    input  logic signed [15:0] binormal_y,
    input  logic signed [15:0] binormal_z,
    input  logic               degenerate,
    output int                 errors,
    output int                 pending,
    output int                 n_results,
    output int                 n_degenerate
);
    typedef struct packed {
        logic [15:0] idx;
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tz;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        logic        degen;
    } basis_t;

    basis_t basis_q[$];

    function automatic logic [63:0] isqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector in q1.14; returns 0 for a zero vector
    function automatic bit unit_q14(input longint v[3], output longint q[3]);
        logic [63:0] a[3];
        logic [63:0] m;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] c;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
            if (a[i] > m)
                m = a[i];
            q[i] = 0;
        end
        if (m == 0)
            return 0;
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] << 1;
        end
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = isqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            c = (a[i] * 64'd32768 + len) / (2 * len);
            q[i] = v[i] < 0 ? -longint'(c) : longint'(c);
        end
        return 1;
    endfunction

    function automatic basis_t predict_basis();
        longint d[3], n[3], t[3], c[3], b[3];
        bit ok_t, ok_b;
        basis_t r;
        d[0] = longint'(to_x) - longint'(from_x);
        d[1] = longint'(to_y) - longint'(from_y);
        d[2] = longint'(to_z) - longint'(from_z);
        n[0] = normal_x;
        n[1] = normal_y;
        n[2] = normal_z;
        ok_t = unit_q14(d, t);
        c[0] = t[1] * n[2] - t[2] * n[1];
        c[1] = t[2] * n[0] - t[0] * n[2];
        c[2] = t[0] * n[1] - t[1] * n[0];
        ok_b = unit_q14(c, b);
        r.idx = vertex_index;
        r.tx = 16'(t[0]);
        r.ty = 16'(t[1]);
        r.tz = 16'(t[2]);
        r.bx = 16'(b[0]);
        r.by = 16'(b[1]);
        r.bz = 16'(b[2]);
        r.degen = !(ok_t && ok_b);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a)
        begin
            $error("%s expected %0h actual %0h", name, e, a);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        n_results = 0;
        n_degenerate = 0;
    end

    assign pending = basis_q.size();

    always @(posedge clk)
    begin
        basis_t e;
        if (rst_n)
        begin
            if (push && !full)
                basis_q.push_back(predict_basis());
            if (pop && !empty)
            begin
                n_results++;
                if (degenerate === 1'b1)
                    n_degenerate++;
                if (basis_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = basis_q.pop_front();
                    check_field("out_index", e.idx, out_index);
                    check_field("tangent_x", e.tx, tangent_x);
                    check_field("tangent_y", e.ty, tangent_y);
                    check_field("tangent_z", e.tz, tangent_z);
                    check_field("binormal_x", e.bx, binormal_x);
                    check_field("binormal_y", e.by, binormal_y);
                    check_field("binormal_z", e.bz, binormal_z);
                    check_field("degenerate", 16'(e.degen), 16'(degenerate));
                end
            end
        end
    end
endmodule

FILE: tb/sv/edge_tangent_binormal_test.sv
// top of the edge tangent testbench: clock, reset, stimulus and verdict
module edge_tangent_binormal_test;
    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic full, empty, degenerate;
    logic [15:0] vertex_index = 0;
    logic signed [31:0] from_x = 0, from_y = 0, from_z = 0;
    logic signed [31:0] to_x = 0, to_y = 0, to_z = 0;
    logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
    logic [15:0] out_index;
    logic signed [15:0] tangent_x, tangent_y, tangent_z;
    logic signed [15:0] binormal_x, binormal_y, binormal_z;
    int errors, pending, n_results, n_degenerate;
    int cycles = 0;
    int n_edges = 0;

    localparam int LIMIT = 400000;

    always #10 clk = ~clk;

    edge_tangent_binormal dut (.*);

    edge_tangent_binormal_check check (.*);

    // receiver stall pattern: long ready runs, bursty stalls, full stops
    always @(posedge clk)
    begin
        int mode;
        cycles++;
        mode = (cycles / 700) % 4;
        case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((cycles % 64) < 48);
        endcase
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_edge(input logic [15:0] idx,
                             input logic [31:0] fx, input logic [31:0] fy,
                             input logic [31:0] fz, input logic [31:0] tx,
                             input logic [31:0] ty, input logic [31:0] tz,
                             input logic [15:0] nx, input logic [15:0] ny,
                             input logic [15:0] nz);
        push <= 1'b1;
        vertex_index <= idx;
        from_x <= fx;
        from_y <= fy;
        from_z <= fz;
        to_x <= tx;
        to_y <= ty;
        to_z <= tz;
        normal_x <= nx;
        normal_y <= ny;
        normal_z <= nz;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n_edges++;
    endtask

    function automatic logic [31:0] rand_pos(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic logic [15:0] rand_normal(input int kind);
        case (kind)
            0: return 16'($signed($urandom_range(0, 32768)) - 16384);
            1: return 16'($urandom);
            2: return 16'($signed($urandom_range(0, 4)) - 2);
            default: return '0;
        endcase
    endfunction

    initial
    begin
        logic [31:0] f[3];
        logic [31:0] t[3];
        logic [15:0] n[3];
        int gap;
        int burst;
        int pk;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // extremes, zero edge, zero and parallel normals
        send_edge(16'h0000, 0, 0, 0, 32'h10000, 0, 0, 16'd0, 16'd0, 16'sd16384);
        send_edge(16'hffff, 0, 0, 0, 0, 0, 0, 16'd0, 16'd0, 16'sd16384);
        send_edge(16'h0001, 5, 5, 5, 5, 5, 5, 16'd0, 16'd0, 16'd0);
        send_edge(16'h8000, 0, 0, 0, 32'h10000, 0, 0, 16'sd16384, 16'd0, 16'd0);
        send_edge(16'h7fff, 0, 0, 0, 32'h10000, 0, 0, 16'd0, 16'd0, 16'd0);
        send_edge(16'h5555, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h8000, 16'h7fff, 16'h0);
        send_edge(16'haaaa, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 16'hc000, 16'hffff, 16'h4000);
        send_edge(16'h1234, 0, 0, 0, 1, 0, 0, 16'd0, 16'sd16384, 16'd0);
        send_edge(16'h4321, 0, 0, 0, 1, 1, 1, 16'hc000, 16'sd16384, 16'sd1);
        send_edge(16'h00ff, 0, 0, 0, 32'hffffffff, 0, 0, 16'hc000, 16'd0, 16'd0);
        send_edge(16'hff00, 0, 0, 0, 0, 32'h10000, 32'h10000, 16'd0, 16'sd16384, 16'sd16384);
        send_edge(16'h0f0f, 32'h12345678, 0, 0, 32'h12345678, 0, 32'h3, 16'sd1, 16'sd1, 16'sd1);
        while (n_edges < 1262)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                pk = $urandom_range(0, 3);
                for (int i = 0; i < 3; i++)
                begin
                    f[i] = rand_pos(pk);
                    t[i] = ($urandom_range(0, 15) == 0) ? f[i] : rand_pos(pk);
                    n[i] = rand_normal($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3));
                end
                // parallel normal now and then
                if ($urandom_range(0, 15) == 0)
                begin
                    n[0] = 16'(longint'($signed(t[0] - f[0])) >>> 18);
                    n[1] = 16'(longint'($signed(t[1] - f[1])) >>> 18);
                    n[2] = 16'(longint'($signed(t[2] - f[2])) >>> 18);
                end
                send_edge(16'($urandom), f[0], f[1], f[2], t[0], t[1], t[2],
                          n[0], n[1], n[2]);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d edges, checked %0d results, %0d of them degenerate",
                 n_edges, n_results, n_degenerate);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/etb_pkg.sv
design/etb_norm.sv
design/etb_front.sv
design/etb_back.sv
design/edge_tangent_binormal.sv
tb/sv/edge_tangent_binormal_check.sv
tb/sv/edge_tangent_binormal_test.sv
